>>> src/ppbd_pkg.sv
`timescale 1ns / 1ps
package ppbd_pkg;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic               last_vertex;
   } req_word_type;

   typedef struct packed {
      logic [24:0] min_distance;
      logic        too_few_vertices;
   } rsp_word_type;

   // Segment job handed from the front to the back.
   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic               open_poly;
      logic               close_poly;
      logic               single;
   } job_type;

   localparam int JobWidth = $bits(job_type);
   localparam int QueueDepth = 4;
   localparam int QueueAddrWidth = 2;
   localparam logic [49:0] BestInit = {50{1'b1}};

endpackage

>>> src/ppbd_queue.sv
`timescale 1ns / 1ps
module ppbd_queue
   import ppbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   job_type                   store_ff [QueueDepth];
   logic [QueueAddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueAddrWidth:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full = (count_ff == (QueueAddrWidth+1)'(QueueDepth));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueueAddrWidth'(do_push);
      rd_ptr_in = rd_ptr_ff + QueueAddrWidth'(do_pop);
      count_in = count_ff + (QueueAddrWidth+1)'(do_push) - (QueueAddrWidth+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/ppbd_front.sv
`timescale 1ns / 1ps
module ppbd_front
   import ppbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_word_type req_word,
   output logic         full,
   output logic         job_push,
   output job_type      job_data,
   input  logic         job_full
);

   typedef enum logic [1:0] {ST_TAKE, ST_CLOSE} state_type;

   state_type          state_ff;
   logic               started_ff;
   logic signed [15:0] qx_ff, qy_ff, fx_ff, fy_ff, px_ff, py_ff;
   logic               accept;

   assign full = job_full || (state_ff == ST_CLOSE);
   assign accept = push && !full;

   always_comb begin
      job_data = '0;
      job_push = 1'b0;
      if (state_ff == ST_CLOSE) begin
         job_push = 1'b1;
         job_data.ax = px_ff;
         job_data.ay = py_ff;
         job_data.bx = fx_ff;
         job_data.by = fy_ff;
         job_data.qx = qx_ff;
         job_data.qy = qy_ff;
         job_data.close_poly = 1'b1;
      end else if (accept) begin
         job_push = 1'b1;
         job_data.bx = req_word.vertex_x;
         job_data.by = req_word.vertex_y;
         if (!started_ff) begin
            job_data.open_poly = 1'b1;
            job_data.single = req_word.last_vertex;
         end else begin
            job_data.ax = px_ff;
            job_data.ay = py_ff;
            job_data.qx = qx_ff;
            job_data.qy = qy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         started_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_TAKE: begin
               if (accept) begin
                  if (!started_ff) begin
                     qx_ff <= req_word.point_x;
                     qy_ff <= req_word.point_y;
                     fx_ff <= req_word.vertex_x;
                     fy_ff <= req_word.vertex_y;
                     started_ff <= !req_word.last_vertex;
                  end else if (req_word.last_vertex) begin
                     state_ff <= ST_CLOSE;
                  end
                  px_ff <= req_word.vertex_x;
                  py_ff <= req_word.vertex_y;
               end
            end
            ST_CLOSE: begin
               if (!job_full) begin
                  state_ff <= ST_TAKE;
                  started_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end

endmodule

>>> src/ppbd_back.sv
`timescale 1ns / 1ps
module ppbd_back
   import ppbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      job_data,
   input  logic         job_empty,
   output logic         job_pop,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_VEC, ST_DOT, ST_SEL, ST_DIV, ST_FOOT, ST_SQA, ST_SQB, ST_KEEP,
      ST_ROOT, ST_OUT
   } state_type;

   state_type          state_ff;
   job_type            job_ff;
   logic signed [16:0] vx_ff, vy_ff, wx_ff, wy_ff, ex_ff, ey_ff;
   logic signed [33:0] pa_ff, pb_ff;
   logic signed [34:0] c1_ff;
   logic [33:0]        c2_ff;
   logic [50:0]        rem_ff;
   logic [16:0]        t_ff;
   logic [4:0]         cnt_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic [67:0]        sq_ff;
   logic [49:0]        best_ff, cand_ff;
   logic [49:0]        rv_ff;
   logic [24:0]        res_ff;
   logic [24:0]        rsp_dist_ff;
   logic               rsp_single_ff;
   logic [4:0]         rcnt_ff;
   logic               valid_ff, single_ff;
   logic [50:0]        rem_shift;
   logic [33:0]        mx, my;
   logic [27:0]        rtrial;
   logic [27:0]        rshift;
   logic [27:0]        racc_ff;

   assign job_pop = (state_ff == ST_IDLE) && !job_empty;
   assign empty = !valid_ff;
   assign rsp_word.min_distance = rsp_dist_ff;
   assign rsp_word.too_few_vertices = rsp_single_ff;
   assign rem_shift = {rem_ff[49:0], 1'b0};
   assign mx = dx_ff[33] ? 34'(-dx_ff) : 34'(dx_ff);
   assign my = dy_ff[33] ? 34'(-dy_ff) : 34'(dy_ff);
   assign rtrial = {1'b0, res_ff, 2'b01};
   assign rshift = {racc_ff[25:0], rv_ff[49:48]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         best_ff <= BestInit;
      end else begin
         if (valid_ff && pop) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  job_ff <= job_data;
                  if (job_data.open_poly) begin
                     best_ff <= BestInit;
                     if (job_data.single) begin
                        state_ff <= ST_OUT;
                        res_ff <= '0;
                        single_ff <= 1'b1;
                     end
                  end else begin
                     state_ff <= ST_VEC;
                  end
               end
            end
            ST_VEC: begin
               vx_ff <= 17'(job_ff.bx) - 17'(job_ff.ax);
               vy_ff <= 17'(job_ff.by) - 17'(job_ff.ay);
               wx_ff <= 17'(job_ff.qx) - 17'(job_ff.ax);
               wy_ff <= 17'(job_ff.qy) - 17'(job_ff.ay);
               ex_ff <= 17'(job_ff.qx) - 17'(job_ff.bx);
               ey_ff <= 17'(job_ff.qy) - 17'(job_ff.by);
               state_ff <= ST_DOT;
            end
            ST_DOT: begin
               pa_ff <= vx_ff * wx_ff;
               pb_ff <= vy_ff * wy_ff;
               c2_ff <= 34'(vx_ff * vx_ff);
               rem_ff <= 51'(vy_ff * vy_ff);
               state_ff <= ST_SEL;
            end
            ST_SEL: begin
               c1_ff <= 35'(pa_ff) + 35'(pb_ff);
               c2_ff <= c2_ff + rem_ff[33:0];
               state_ff <= ST_DIV;
               cnt_ff <= '0;
               t_ff <= '0;
            end
            ST_DIV: begin
               if (cnt_ff == '0 && (c1_ff[34] || c1_ff == '0)) begin
                  dx_ff <= 34'(wx_ff) <<< 16;
                  dy_ff <= 34'(wy_ff) <<< 16;
                  state_ff <= ST_SQA;
               end else if (cnt_ff == '0 && 35'(c2_ff) <= c1_ff) begin
                  dx_ff <= 34'(ex_ff) <<< 16;
                  dy_ff <= 34'(ey_ff) <<< 16;
                  state_ff <= ST_SQA;
               end else begin
                  if (cnt_ff == '0) begin
                     rem_ff <= 51'(c1_ff[33:0]);
                     t_ff <= '0;
                     cnt_ff <= 5'd1;
                  end else begin
                     if (rem_shift >= 51'(c2_ff)) begin
                        rem_ff <= rem_shift - 51'(c2_ff);
                        t_ff <= {t_ff[15:0], 1'b1};
                     end else begin
                        rem_ff <= rem_shift;
                        t_ff <= {t_ff[15:0], 1'b0};
                     end
                     if (cnt_ff == 5'd16) begin
                        state_ff <= ST_FOOT;
                     end else begin
                        cnt_ff <= cnt_ff + 5'd1;
                     end
                  end
               end
            end
            ST_FOOT: begin
               dx_ff <= (34'(wx_ff) <<< 16) - 34'($signed({1'b0, t_ff}) * vx_ff);
               dy_ff <= (34'(wy_ff) <<< 16) - 34'($signed({1'b0, t_ff}) * vy_ff);
               state_ff <= ST_SQA;
            end
            ST_SQA: begin
               sq_ff <= 68'(mx) * 68'(mx);
               state_ff <= ST_SQB;
            end
            ST_SQB: begin
               cand_ff <= 50'((sq_ff + (68'(my) * 68'(my))) >> 16);
               state_ff <= ST_KEEP;
            end
            ST_KEEP: begin
               if (cand_ff < best_ff) begin
                  best_ff <= cand_ff;
                  rv_ff <= cand_ff;
               end else begin
                  rv_ff <= best_ff;
               end
               racc_ff <= '0;
               res_ff <= '0;
               rcnt_ff <= '0;
               state_ff <= job_ff.close_poly ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
               if (rshift >= rtrial) begin
                  racc_ff <= rshift - rtrial;
                  res_ff <= {res_ff[23:0], 1'b1};
               end else begin
                  racc_ff <= rshift;
                  res_ff <= {res_ff[23:0], 1'b0};
               end
               rv_ff <= {rv_ff[47:0], 2'b00};
               single_ff <= 1'b0;
               if (rcnt_ff == 5'd24) begin
                  state_ff <= ST_OUT;
               end else begin
                  rcnt_ff <= rcnt_ff + 5'd1;
               end
            end
            ST_OUT: begin
               if (!valid_ff) begin
                  valid_ff <= 1'b1;
                  rsp_dist_ff <= res_ff;
                  rsp_single_ff <= single_ff;
                  best_ff <= BestInit;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> src/point_polygon_boundary_distance.sv
`timescale 1ns / 1ps
// Minimum distance from a query point to a polygon's boundary. Vertices enter one word at a
// time; each vertex after the first becomes a segment job in a four-entry queue, and the
// last vertex adds the closing segment. The back end takes one segment job at a time and
// uses the restoring divider (one quotient bit per cycle) only for a segment whose closest
// point lies strictly inside it; after the closing segment it takes the bit-serial square
// root of the smallest squared distance to give the result.
module point_polygon_boundary_distance
   import ppbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_word,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_word
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;

   ppbd_front u_front (
      .clock(clock), .reset(reset), .push(push), .req_word(req_word), .full(full),
      .job_push(job_push), .job_data(job_in), .job_full(job_full)
   );

   ppbd_queue u_queue (
      .clock(clock), .reset(reset), .push(job_push), .push_data(job_in), .full(job_full),
      .pop(job_pop), .pop_data(job_out), .empty(job_empty)
   );

   ppbd_back u_back (
      .clock(clock), .reset(reset), .job_data(job_out), .job_empty(job_empty),
      .job_pop(job_pop), .empty(empty), .pop(pop), .rsp_word(rsp_word)
   );

   a_full_when_queue_full: assert property (@(posedge clock) disable iff (reset)
      job_full |-> full) else $error("input taken while job queue full");

   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.too_few_vertices) |-> (rsp_word.min_distance == '0))
      else $error("single-vertex result not zero");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("waiting result changed");

endmodule
